// ===== hdl/swf_pkg.sv =====
// shared constants and types for the scan wall-follow pd controller
package swf_pkg;

  localparam int MaxScanDefault = 4096;
  localparam int HalfPiQ20 = 1647099;
  localparam int QueueDepth = 4;

  localparam logic [2:0] RegWallDistance = 3'd0;
  localparam logic [2:0] RegMaxSpeed = 3'd1;
  localparam logic [2:0] RegPropGain = 3'd2;
  localparam logic [2:0] RegDerivGain = 3'd3;
  localparam logic [2:0] RegAngleStep = 3'd4;
  localparam logic [2:0] RegScanLength = 3'd5;

  typedef struct packed {
    logic [15:0] wall_distance;
    logic [15:0] max_speed;
    logic [15:0] kp;
    logic [15:0] kd;
    logic [19:0] angle_step;
  } cfg_t;

endpackage

// ===== hdl/scan_wall_follow_pd.sv =====
// top level of the scan wall-follow pd controller: register file and front/back split
//
//   channel | signals                                     | moves
//   in      | in_valid, in_stall, range_sample            | one range sample per request
//   out     | out_valid, out_stall, angular_rate, lin.spd | one drive command per scan
//   config  | psel, penable, pwrite, paddr, pwdata, ...   | register writes and reads
//
// one sample is taken every cycle while in_stall is low; the scan counter and running minimum
// close each item. a command reaches the output register from the last sample of its scan
// through a four-entry queue and three math stages.
// rst is synchronous; it clears counters, queue and valids and loads register defaults.
// in_stall rises only when four finished scans are queued behind a stalled output.
module scan_wall_follow_pd import swf_pkg::*; #(
  parameter int MAX_SCAN = MaxScanDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        range_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] angular_rate,
  output logic [15:0]        linear_speed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = $clog2(MAX_SCAN);
  localparam int LW = $clog2(MAX_SCAN + 1);
  localparam int JW = 32 + IW + LW - 1;

  cfg_t          cfg;
  logic [12:0]   scan_length;
  logic          wr_en;
  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  logic [JW-1:0] q_din;
  logic [JW-1:0] q_dout;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wall_distance <= 16'd512;
      cfg.max_speed <= 16'd51;
      cfg.kp <= 16'd2560;
      cfg.kd <= 16'd1280;
      cfg.angle_step <= 20'd18304;
      scan_length <= 13'd1024;
    end else if (wr_en) begin
      case (paddr[4:2])
        RegWallDistance: cfg.wall_distance <= pwdata[15:0];
        RegMaxSpeed:     cfg.max_speed <= pwdata[15:0];
        RegPropGain:     cfg.kp <= pwdata[15:0];
        RegDerivGain:    cfg.kd <= pwdata[15:0];
        RegAngleStep:    cfg.angle_step <= pwdata[19:0];
        RegScanLength:   scan_length <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegWallDistance: prdata = {16'd0, cfg.wall_distance};
      RegMaxSpeed:     prdata = {16'd0, cfg.max_speed};
      RegPropGain:     prdata = {16'd0, cfg.kp};
      RegDerivGain:    prdata = {16'd0, cfg.kd};
      RegAngleStep:    prdata = {12'd0, cfg.angle_step};
      RegScanLength:   prdata = {19'd0, scan_length};
      default:         prdata = 32'd0;
    endcase
  end

  swf_front #(.MAX_SCAN(MAX_SCAN), .IW(IW), .LW(LW), .JW(JW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .scan_length  (scan_length),
    .in_valid     (in_valid),
    .range_sample (range_sample),
    .in_stall     (in_stall),
    .full         (q_full),
    .push         (q_push),
    .job          (q_din)
  );

  swf_queue #(.W(JW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  swf_back #(.MAX_SCAN(MAX_SCAN), .IW(IW), .LW(LW), .JW(JW)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (~q_empty),
    .job          (q_dout),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .angular_rate (angular_rate),
    .linear_speed (linear_speed)
  );

endmodule

// ===== hdl/swf_queue.sv =====
// short fifo carrying finished scan summaries from front to back
module swf_queue import swf_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);

  localparam int PW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);

  logic [W-1:0]  entries [QueueDepth];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full = (count == CW'(QueueDepth));
  assign empty = (count == '0);
  assign do_push = push & ~full;
  assign do_pop = pop & ~empty;
  assign dout = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + PW'(1);
      if (do_pop) rptr <= rptr + PW'(1);
      if (do_push & ~do_pop) count <= count + CW'(1);
      else if (do_pop & ~do_push) count <= count - CW'(1);
    end
  end

endmodule

// ===== hdl/swf_front.sv =====
// front end: takes range samples, tracks nearest range over the first half and front range, closes each scan
module swf_front import swf_pkg::*; #(
  parameter int MAX_SCAN = MaxScanDefault,
  parameter int IW = $clog2(MAX_SCAN),
  parameter int LW = $clog2(MAX_SCAN + 1),
  parameter int JW = 32 + IW + LW - 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [12:0]   scan_length,
  input  logic          in_valid,
  input  logic [15:0]   range_sample,
  output logic          in_stall,
  input  logic          full,
  output logic          push,
  output logic [JW-1:0] job
);

  logic [IW-1:0] sample_index;
  logic [15:0]   nearest_range;
  logic [IW-1:0] nearest_index;
  logic [15:0]   front_range;
  logic [15:0]   nearest_range_next;
  logic [IW-1:0] nearest_index_next;
  logic [15:0]   front_range_next;
  logic [31:0]   len_w;
  logic [LW-1:0] len;
  logic [LW-2:0] half;
  logic          accept;
  logic          last;

  // clamp the configured length into the supported span
  always_comb begin
    if (scan_length < 13'd2) len_w = 32'd2;
    else if ({19'd0, scan_length} > 32'(MAX_SCAN)) len_w = 32'(MAX_SCAN);
    else len_w = {19'd0, scan_length};
  end

  assign len = len_w[LW-1:0];
  assign half = len[LW-1:1];
  assign accept = in_valid & ~full;
  assign in_stall = full;
  // length may shrink mid scan, so anything at or past the end closes it
  assign last = LW'(sample_index) >= (len - LW'(1));
  assign push = accept & last;

  always_comb begin
    nearest_range_next = nearest_range;
    nearest_index_next = nearest_index;
    front_range_next = front_range;
    if (sample_index == '0) begin
      nearest_range_next = range_sample;
      nearest_index_next = '0;
    end else if ((LW'(sample_index) < LW'(half)) && (range_sample < nearest_range)) begin
      nearest_range_next = range_sample;
      nearest_index_next = sample_index;
    end
    if (LW'(sample_index) == LW'(half)) front_range_next = range_sample;
  end

  assign job = {front_range_next, nearest_range_next, nearest_index_next, half};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      nearest_range <= '0;
      nearest_index <= '0;
      front_range <= '0;
    end else if (accept) begin
      nearest_range <= nearest_range_next;
      nearest_index <= nearest_index_next;
      front_range <= front_range_next;
      if (last) sample_index <= '0;
      else sample_index <= sample_index + IW'(1);
    end
  end

endmodule

// ===== hdl/swf_back.sv =====
// back end: pd steering math over three stages plus an output register
module swf_back import swf_pkg::*; #(
  parameter int MAX_SCAN = MaxScanDefault,
  parameter int IW = $clog2(MAX_SCAN),
  parameter int LW = $clog2(MAX_SCAN + 1),
  parameter int JW = 32 + IW + LW - 1
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               job_valid,
  input  logic [JW-1:0]      job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] angular_rate,
  output logic [15:0]        linear_speed
);

  localparam int DW = LW + 1;
  localparam int AW = DW + 21;
  localparam int SW = ((AW > 38) ? AW : 38) + 2;
  localparam logic signed [SW-1:0] HalfPi = SW'(HalfPiQ20);
  localparam logic signed [SW-1:0] RoundBias = SW'(128);
  localparam logic signed [SW-9:0] SatHi = (SW-8)'(32767);
  localparam logic signed [SW-9:0] SatLo = -(SW-8)'(32768);

  logic [15:0]   job_front;
  logic [15:0]   job_nearest;
  logic [IW-1:0] job_index;
  logic [LW-2:0] job_half;

  logic                  adv;
  logic signed [16:0]    previous_error;
  logic signed [16:0]    err_c;
  logic signed [17:0]    der_c;

  logic                  v1;
  logic signed [16:0]    err1;
  logic signed [17:0]    der1;
  logic signed [DW-1:0]  diff1;
  logic                  fok1;

  logic                  v2;
  logic signed [33:0]    p2;
  logic signed [34:0]    d2;
  logic signed [AW-1:0]  a2;
  logic                  fok2;

  logic                  v3;
  logic signed [SW-1:0]  sum3;
  logic                  fok3;

  logic signed [SW-1:0]  rounded;
  logic signed [SW-9:0]  q;
  logic signed [15:0]    q_sat;

  assign {job_front, job_nearest, job_index, job_half} = job;

  // whole pipe freezes only while a finished command waits
  assign adv = ~out_valid | ~out_stall;
  assign pop = adv & job_valid;

  assign err_c = $signed({1'b0, job_nearest}) - $signed({1'b0, cfg.wall_distance});
  assign der_c = {err_c[16], err_c} - {previous_error[16], previous_error};

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
    end else if (pop) begin
      previous_error <= err_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err1 <= err_c;
      der1 <= der_c;
      diff1 <= $signed(DW'(job_index)) - $signed(DW'(job_half));
      fok1 <= ~(job_front < cfg.wall_distance);
      p2 <= $signed({1'b0, cfg.kp}) * err1;
      d2 <= $signed({1'b0, cfg.kd}) * der1;
      a2 <= diff1 * $signed({1'b0, cfg.angle_step});
      fok2 <= fok1;
      sum3 <= SW'(a2) + HalfPi - ((SW'(p2) + SW'(d2)) <<< 2);
      fok3 <= fok2;
      angular_rate <= q_sat;
      linear_speed <= fok3 ? cfg.max_speed : 16'd0;
    end
  end

  // round to nearest with ties upward, then clip to 16 bits
  assign rounded = (sum3 + RoundBias) >>> 8;
  assign q = rounded[SW-9:0];

  always_comb begin
    if (q > SatHi) q_sat = 16'sd32767;
    else if (q < SatLo) q_sat = -16'sd32768;
    else q_sat = q[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= pop;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

endmodule
